[hdl/hne_pkg.sv]
// ----------------------------------------------------------------------------
// hne_pkg
// Shared types and constants of the numeric entity encoder.
// ----------------------------------------------------------------------------
package hne_pkg;

   localparam int CODE_W     = 21;   // widest code point
   localparam int DIGITS_MAX = 7;    // decimal digits of a 21-bit value
   localparam int DCNT_W     = $clog2(DIGITS_MAX + 1);

   // q = (v * DIV10_MAGIC) >> DIV10_SHIFT is exact for v < 2**22
   localparam int                DIV10_SHIFT = 24;
   localparam int                MAGIC_W     = 21;
   localparam logic [MAGIC_W-1:0] DIV10_MAGIC = 21'h19999A;

   // register indexes
   localparam logic CSR_XML_MODE  = 1'b0;
   localparam logic CSR_UTF8_MODE = 1'b1;

   localparam logic [7:0] CHAR_AMP   = 8'h26;  // '&'
   localparam logic [7:0] CHAR_HASH  = 8'h23;  // '#'
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ';'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;

   typedef enum logic [2:0] {
      EMIT_BYTE,
      EMIT_AMP,
      EMIT_HASH,
      EMIT_DIGIT,
      EMIT_SEMI
   } emit_sel_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_PASS,
      ACT_ENTITY
   } action_type;

   typedef struct packed {
      logic         accept;
      logic         conv_step;
      logic         emit;
      emit_sel_type emit_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       conv_done;
      logic       last_digit;
      logic       digits_avail;
      logic       out_free;
   } dp_status_type;

endpackage

[hdl/html_numeric_entity_encoder.sv]
// ----------------------------------------------------------------------------
// html_numeric_entity_encoder
// Byte stream in, text stream out with illegal characters as "&#N;" entities.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per beat, rsp_* carries output characters;
//   rsp_tlast marks the final character produced for one input byte.
//   csr_* writes xml_mode (index 0) and utf8_mode (index 1); write them only
//   while no entity is being produced.
// Timing:
//   A passed byte is taken and its beat appears on the next cycle, so
//   legal text streams at one byte per cycle while rsp_tready stays high.
//   UTF-8 lead and middle bytes are also taken and produce nothing.
//   A byte that becomes an entity of N digits (1..7) is accepted, then
//   takes N divide-by-ten steps through one multiplier, then N + 3 output
//   beats; req_tready is low meanwhile.
//   A byte can be taken in the same cycle the previous output beat is taken.
// Reset:
//   Synchronous; clears both mode bits, the pending UTF-8 sequence and the
//   output valid flag.
// Stall:
//   When rsp_tready is low the held beat stays put and the block stops
//   accepting input until the beat is taken.
// ----------------------------------------------------------------------------
module html_numeric_entity_encoder
   import hne_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic       csr_wdata,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   hne_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   hne_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_byte    (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a held beat is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("output beat overwritten while stalled");

   // no input is taken while a conversion is running
   assert property (@(posedge clock) disable iff (reset)
      cmd.conv_step |-> !req_tready)
      else $error("input accepted during digit conversion");

   // digit beats only come from a filled digit stack
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.emit_sel == EMIT_DIGIT)) |-> sts.digits_avail)
      else $error("digit emitted from empty stack");

   // a conversion keeps stepping until the quotient is zero
   assert property (@(posedge clock) disable iff (reset)
      (cmd.conv_step && !sts.conv_done) |=> cmd.conv_step)
      else $error("conversion left early");

endmodule

[hdl/hne_ctrl.sv]
// ----------------------------------------------------------------------------
// hne_ctrl
// Sequencer: accepts bytes, runs the decimal conversion and the entity beats.
// ----------------------------------------------------------------------------
module hne_ctrl
   import hne_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_AMP,
      ST_HASH,
      ST_DIGIT,
      ST_SEMI
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      in_ready     = 1'b0;
      cmd.accept   = 1'b0;
      cmd.conv_step = 1'b0;
      cmd.emit     = 1'b0;
      cmd.emit_sel = EMIT_BYTE;
      case (state_ff)
         ST_IDLE: begin
            in_ready   = sts.out_free;
            cmd.accept = in_valid && sts.out_free;
            cmd.emit   = cmd.accept && (sts.action == ACT_PASS);
            if (cmd.accept && (sts.action == ACT_ENTITY)) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_AMP;
            end
         end
         ST_AMP: begin
            cmd.emit     = sts.out_free;
            cmd.emit_sel = EMIT_AMP;
            if (sts.out_free) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.emit     = sts.out_free;
            cmd.emit_sel = EMIT_HASH;
            if (sts.out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.emit     = sts.out_free;
            cmd.emit_sel = EMIT_DIGIT;
            if (sts.out_free && sts.last_digit) begin
               state_in = ST_SEMI;
            end
         end
         ST_SEMI: begin
            cmd.emit     = sts.out_free;
            cmd.emit_sel = EMIT_SEMI;
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/hne_dp.sv]
// ----------------------------------------------------------------------------
// hne_dp
// Datapath: mode registers, UTF-8 gathering, divide-by-ten digit stack and
// the output beat register.
// ----------------------------------------------------------------------------
module hne_dp
   import hne_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic          csr_wdata,
   input  logic [7:0]    in_byte,
   input  ctrl_cmd_type  cmd,
   output dp_status_type sts,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic          rsp_tlast
);

   localparam int PROD_W = CODE_W + MAGIC_W;

   logic              xml_mode_ff;
   logic              utf8_mode_ff;
   logic [CODE_W-1:0] acc_ff, acc_in;
   logic [1:0]        pend_ff, pend_in;
   logic [CODE_W-1:0] ent_val;
   action_type        action;

   logic [CODE_W-1:0] conv_ff, conv_in;
   logic [PROD_W-1:0] prod;
   logic [CODE_W-1:0] quot;
   logic [CODE_W-1:0] quot10;
   logic [3:0]        rem;
   logic [3:0]        dig_ff [DIGITS_MAX];
   logic [3:0]        dig_in [DIGITS_MAX];
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   logic              out_valid_ff;
   logic [7:0]        out_char_ff;
   logic              out_last_ff;
   logic [7:0]        emit_char;

   function automatic logic byte_legal(input logic [7:0] b, input logic xml);
      logic res;
      if (xml) begin
         res = (b >= CHAR_SPACE) && (b <= CHAR_TILDE);
      end else begin
         res = (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
               (b == CHAR_COLON) || (b == CHAR_DOT) || (b == CHAR_DASH) ||
               (b == CHAR_SLASH) || (b == CHAR_SPACE);
      end
      return res;
   endfunction

   // classify the byte on the input and work out the UTF-8 state after it
   always_comb begin
      logic [CODE_W-1:0] acc_ext;
      logic              legal;
      acc_ext = {acc_ff[CODE_W-7:0], in_byte[5:0]};
      legal   = byte_legal(in_byte, xml_mode_ff);
      ent_val = CODE_W'(in_byte);
      acc_in  = '0;
      pend_in = '0;
      action  = legal ? ACT_PASS : ACT_ENTITY;
      if (utf8_mode_ff) begin
         if ((pend_ff != 2'd0) && (in_byte inside {[8'h80:8'hBF]})) begin
            if (pend_ff == 2'd1) begin
               ent_val = acc_ext;
               action  = ACT_ENTITY;
            end else begin
               acc_in  = acc_ext;
               pend_in = pend_ff - 2'd1;
               action  = ACT_NONE;
            end
         end else if (!legal) begin
            // a broken sequence is dropped; the byte starts over
            if (in_byte inside {[8'hC2:8'hDF]}) begin
               acc_in  = CODE_W'(in_byte[4:0]);
               pend_in = 2'd1;
               action  = ACT_NONE;
            end else if (in_byte inside {[8'hE0:8'hEF]}) begin
               acc_in  = CODE_W'(in_byte[3:0]);
               pend_in = 2'd2;
               action  = ACT_NONE;
            end else if (in_byte inside {[8'hF0:8'hF4]}) begin
               acc_in  = CODE_W'(in_byte[2:0]);
               pend_in = 2'd3;
               action  = ACT_NONE;
            end
         end
      end
   end

   // one decimal digit per step, by reciprocal multiply
   always_comb begin
      prod   = PROD_W'(conv_ff) * PROD_W'(DIV10_MAGIC);
      quot   = CODE_W'(prod[PROD_W-1:DIV10_SHIFT]);
      quot10 = (quot << 3) + (quot << 1);
      rem    = 4'(conv_ff - quot10);
   end

   always_comb begin
      conv_in = conv_ff;
      dcnt_in = dcnt_ff;
      for (int i = 0; i < DIGITS_MAX; i++) begin
         dig_in[i] = dig_ff[i];
      end
      if (cmd.accept) begin
         conv_in = ent_val;
         dcnt_in = '0;
      end else if (cmd.conv_step) begin
         conv_in   = quot;
         dcnt_in   = dcnt_ff + DCNT_W'(1);
         dig_in[0] = rem;
         for (int i = 1; i < DIGITS_MAX; i++) begin
            dig_in[i] = dig_ff[i-1];
         end
      end else if (cmd.emit && (cmd.emit_sel == EMIT_DIGIT)) begin
         // pop the most significant digit
         dcnt_in = dcnt_ff - DCNT_W'(1);
         for (int i = 0; i < DIGITS_MAX - 1; i++) begin
            dig_in[i] = dig_ff[i+1];
         end
         dig_in[DIGITS_MAX-1] = '0;
      end
   end

   always_comb begin
      case (cmd.emit_sel)
         EMIT_BYTE:  emit_char = in_byte;
         EMIT_AMP:   emit_char = CHAR_AMP;
         EMIT_HASH:  emit_char = CHAR_HASH;
         EMIT_DIGIT: emit_char = CHAR_ZERO + {4'b0000, dig_ff[0]};
         EMIT_SEMI:  emit_char = CHAR_SEMI;
         default:    emit_char = CHAR_SEMI;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xml_mode_ff  <= 1'b0;
         utf8_mode_ff <= 1'b0;
         acc_ff       <= '0;
         pend_ff      <= '0;
         dcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index == CSR_XML_MODE)) begin
            xml_mode_ff <= csr_wdata;
         end
         if (csr_wr_en && (csr_index == CSR_UTF8_MODE)) begin
            utf8_mode_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            acc_ff  <= acc_in;
            pend_ff <= pend_in;
         end
         dcnt_ff <= dcnt_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      conv_ff <= conv_in;
      for (int i = 0; i < DIGITS_MAX; i++) begin
         dig_ff[i] <= dig_in[i];
      end
      if (cmd.emit) begin
         out_char_ff <= emit_char;
         out_last_ff <= (cmd.emit_sel == EMIT_BYTE) || (cmd.emit_sel == EMIT_SEMI);
      end
   end

   assign sts.action       = action;
   assign sts.conv_done    = (quot == '0);
   assign sts.last_digit   = (dcnt_ff == DCNT_W'(1));
   assign sts.digits_avail = (dcnt_ff != '0);
   assign sts.out_free     = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
